// ===== rtl/key_matrix_scan_debouncer_unit_assert.svh =====
`ifndef KEY_MATRIX_SCAN_DEBOUNCER_UNIT_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define KMSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define KMSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kmsd_pkg.sv =====
package kmsd_pkg;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

  localparam int COL_W   = 3;
  localparam int ROWIN_W = 16;
  localparam int QUERY_W = 4;
  localparam int KEYS_W  = 8;
  localparam int COUNT_W = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [COL_W-1:0]   column_index;
    logic [ROWIN_W-1:0] row_bits;
    logic               scan_end;
    logic [QUERY_W-1:0] query_row;
  } kmsd_item_t;

  typedef struct packed {
    logic               settled;
    logic               bounce_seen;
    logic [KEYS_W-1:0]  row_keys;
    logic               ghost;
    logic [COUNT_W-1:0] key_count;
  } kmsd_result_t;

endpackage

// ===== rtl/kmsd_matrix.sv =====
module kmsd_matrix
  import kmsd_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         upd,
  input  kmsd_item_t   item,
  input  logic [7:0]   debounce_scans,
  output kmsd_result_t res
);

  localparam int CW = $clog2(ROWS * COLS + 1);
  localparam int RW = $clog2(ROWS + 1);
  localparam int QW = (COLS > KEYS_W) ? COLS : KEYS_W;

  logic [COLS-1:0] raw [ROWS];
  logic [COLS-1:0] raw_next [ROWS];
  logic [COLS-1:0] stable [ROWS];
  logic [COLS-1:0] stable_next [ROWS];
  logic [ROWS-1:0] col_v [COLS];
  logic [COLS-1:0] multi, multi_next;
  logic [CW-1:0]   raw_count, raw_count_next;
  logic [CW-1:0]   stable_count, stable_count_next;
  logic [7:0]      counter, counter_a, counter_next, reload;
  logic [COLS-1:0] col_sel;
  logic [31:0]     rows_x;
  logic [ROWS-1:0] up, dn;
  logic [RW-1:0]   n_up, n_dn;
  logic            changed, bounce, copy;
  logic [COLS-1:0] qrow;
  logic [QW-1:0]   qrow_x;

  // column update, running count of raw keys, settle countdown
  always_comb begin
    rows_x = 32'(item.row_bits);
    for (int c = 0; c < COLS; c++) begin
      col_sel[c] = (32'(item.column_index) == c);
    end
    for (int r = 0; r < ROWS; r++) begin
      raw_next[r] = raw[r];
      for (int c = 0; c < COLS; c++) begin
        if (col_sel[c] && (r < ROWIN_W)) begin
          raw_next[r][c] = rows_x[r];
        end
      end
      up[r] = |(raw_next[r] & ~raw[r]);
      dn[r] = |(raw[r] & ~raw_next[r]);
    end
    n_up = '0;
    n_dn = '0;
    for (int r = 0; r < ROWS; r++) begin
      n_up = n_up + RW'(up[r]);
      n_dn = n_dn + RW'(dn[r]);
    end
    changed        = |(up | dn);
    raw_count_next = raw_count + CW'(n_up) - CW'(n_dn);

    reload    = (debounce_scans != 8'd0) ? debounce_scans : 8'd1;
    bounce    = changed && (counter != 8'd0);
    counter_a = changed ? reload : counter;
    if (item.scan_end && (counter_a != 8'd0)) begin
      counter_next = counter_a - 8'd1;
      copy         = (counter_a == 8'd1);
    end else begin
      counter_next = counter_a;
      copy         = 1'b0;
    end

    // a column shared by two or more rows, kept per column of the stable copy
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        col_v[c][r] = raw_next[r][c];
      end
      multi_next[c] = copy ? ((col_v[c] & (col_v[c] - ROWS'(1))) != '0) : multi[c];
    end
    for (int r = 0; r < ROWS; r++) begin
      stable_next[r] = copy ? raw_next[r] : stable[r];
    end
    stable_count_next = copy ? raw_count_next : stable_count;
  end

  // result from the state after this request
  always_comb begin
    qrow = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (32'(item.query_row) == r) begin
        qrow = stable_next[r];
      end
    end
    qrow_x          = QW'(qrow);
    res.settled     = (counter_next == 8'd0);
    res.bounce_seen = bounce;
    res.row_keys    = qrow_x[KEYS_W-1:0];
    res.ghost       = ((qrow & (qrow - COLS'(1))) != '0) && (|(qrow & multi_next));
    res.key_count   = (32'(stable_count_next) > 32'd255) ? 8'hFF
                                                         : COUNT_W'(stable_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        raw[r]    <= '0;
        stable[r] <= '0;
      end
      multi        <= '0;
      raw_count    <= '0;
      stable_count <= '0;
      counter      <= DEBOUNCE_RESET;
    end else if (upd) begin
      raw          <= raw_next;
      stable       <= stable_next;
      multi        <= multi_next;
      raw_count    <= raw_count_next;
      stable_count <= stable_count_next;
      counter      <= counter_next;
    end
  end

endmodule

// ===== rtl/key_matrix_scan_debouncer_unit.sv =====
// Key matrix scan debouncer. Each request on the s_ side is one column read
// (column, active-high row bits, s_tlast on the last column of a scan); each
// one yields exactly one result on the m_ side describing the matrix after
// that read: settled flag, bounce flag, the stable keys and ghost flag of the
// queried row, and the saturated count of stable keys. One request per clock
// is taken while m_tready low holds no result; a result is offered on m_ once
// its request has passed the input register and then the result register,
// the whole state update done as it enters the latter. s_tready falls only
// while a result is held by m_tready low and the input register is full. The
// user must write debounce_scans on the cfg_ channel (always ready) only while
// no request is in flight; the block itself does not enforce this. A new value
// takes effect at the next reload of the settle counter.
module key_matrix_scan_debouncer_unit
  import kmsd_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] column_index, [18:3] row_bits, [22:19] query_row, [23] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] settled, [1] bounce_seen, [9:2] row_keys, [10] ghost,
  // [18:11] key_count, [23:19] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  logic         in_valid;
  kmsd_item_t   in_item;
  logic         out_valid;
  kmsd_result_t out_res;
  kmsd_result_t res;
  logic [7:0]   debounce_scans;
  logic         out_free, advance;

  assign out_free  = !out_valid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      debounce_scans <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.column_index <= s_tdata[COL_W-1:0];
      in_item.row_bits     <= s_tdata[COL_W +: ROWIN_W];
      in_item.query_row    <= s_tdata[COL_W + ROWIN_W +: QUERY_W];
      in_item.scan_end     <= s_tlast;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  kmsd_matrix #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_matrix (
    .clk            (clk),
    .rst            (rst),
    .upd            (advance),
    .item           (in_item),
    .debounce_scans (debounce_scans),
    .res            (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.key_count, out_res.ghost, out_res.row_keys,
                     out_res.bounce_seen, out_res.settled};

endmodule

// ===== rtl/kmsd_checker.sv =====
`include "key_matrix_scan_debouncer_unit_assert.svh"

module kmsd_checker
  import kmsd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a held result must not change under back-pressure
  `KMSD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "result changed while stalled")

  // a ghost row has two keys plus a key of another row in a shared column
  `KMSD_ASSERT_NOW(a_ghost_count, clk, rst, m_tvalid && m_tdata[10], m_tdata[18:11] >= 8'd3, "ghost with fewer than three keys")

  // the queried row cannot hold more keys than the whole matrix
  `KMSD_ASSERT_NOW(a_row_in_total, clk, rst, m_tvalid, $countones(m_tdata[9:2]) <= 32'(m_tdata[18:11]), "row keys exceed key count")

endmodule

bind key_matrix_scan_debouncer_unit kmsd_checker u_kmsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
